// File: hw/rtl/staw_pkg.sv
// Shared types and constants of the strided tensor address walker.
package staw_pkg;

	localparam int NDIM        = 3;
	localparam int IDX_W       = 16;
	localparam int CNT_W       = 48;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 32;
	localparam int STRIDE_W    = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXTENT_OUTER  = 3'd0,
		REG_EXTENT_MIDDLE = 3'd1,
		REG_EXTENT_INNER  = 3'd2,
		REG_STRIDE_OUTER  = 3'd3,
		REG_STRIDE_MIDDLE = 3'd4,
		REG_STRIDE_INNER  = 3'd5,
		REG_BASE_OFFSET   = 3'd6
	} cfg_reg_t;

	// Extents, index 0 is the outermost dimension.
	typedef struct packed {
		logic [NDIM-1:0][IDX_W-1:0] extent;
	} extent_cfg_t;

	typedef struct packed {
		logic [NDIM-1:0][STRIDE_W-1:0] stride;
		logic [ADDR_W-1:0]             base;
	} addr_cfg_t;

	// Fields that ride along with an element to the output.
	typedef struct packed {
		logic [CNT_W-1:0]  lin;
		logic              last;
		logic [DATA_W-1:0] value;
	} tag_t;

	// One classified element, as queued between front and back.
	typedef struct packed {
		logic [NDIM-1:0][IDX_W-1:0] idx;
		tag_t                       tag;
	} walk_t;

endpackage

// File: hw/rtl/staw_stream_if.sv
// Valid/ready stream interfaces for walker items and results.
interface staw_item_if;
	logic                       valid;
	logic                       ready;
	logic                       restart;
	logic [staw_pkg::DATA_W-1:0] element_value;

	modport source (output valid, output restart, output element_value, input ready);
	modport sink (input valid, input restart, input element_value, output ready);
	modport monitor (input valid, input restart, input element_value, input ready);
endinterface

interface staw_result_if;
	logic                        valid;
	logic                        ready;
	logic [staw_pkg::ADDR_W-1:0] strided_address;
	logic [staw_pkg::CNT_W-1:0]  linear_index;
	logic [staw_pkg::DATA_W-1:0] value_out;
	logic                        last_element;

	modport source (output valid, output strided_address, output linear_index,
		output value_out, output last_element, input ready);
	modport sink (input valid, input strided_address, input linear_index,
		input value_out, input last_element, output ready);
	modport monitor (input valid, input strided_address, input linear_index,
		input value_out, input last_element, input ready);
endinterface

// File: hw/rtl/staw_front.sv
// Front end: accepts items, steps the index counters and classifies each element.
module staw_front #(
	parameter int DIMS        = 3,
	parameter int EXTENT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  staw_pkg::extent_cfg_t ext_cfg,
	staw_item_if.sink             item,
	input  logic                  q_full,
	output logic                  q_push,
	output staw_pkg::walk_t       q_entry
);
	import staw_pkg::*;

	localparam int EW = (EXTENT_BITS < IDX_W) ? EXTENT_BITS : IDX_W;
	localparam logic [IDX_W-1:0] EXT_MASK = IDX_W'((32'd1 << EW) - 32'd1);
	localparam int FIRST_ACTIVE = NDIM - DIMS;

	logic [NDIM-1:0][IDX_W-1:0] idx_q;
	logic [CNT_W-1:0]           lin_q;

	logic [NDIM-1:0][IDX_W-1:0] cur;
	logic [NDIM-1:0][IDX_W-1:0] ext_eff;
	logic [NDIM-1:0][IDX_W-1:0] nxt;
	logic [NDIM-1:0]            at_end;
	logic [CNT_W-1:0]           lin_cur;
	logic [CNT_W-1:0]           lin_nxt;
	logic                       wrap;

	// Classify the element and work out the next position with carry.
	always_comb begin
		logic [IDX_W-1:0] masked;
		logic             carry;
		masked = '0;
		carry  = 1'b1;
		for (int d = 0; d < NDIM; d++) begin
			masked = ext_cfg.extent[d] & EXT_MASK;
			if (d < FIRST_ACTIVE || masked == '0) begin
				ext_eff[d] = IDX_W'(1);
			end else begin
				ext_eff[d] = masked;
			end
			if (item.restart || d < FIRST_ACTIVE) begin
				cur[d] = '0;
			end else begin
				cur[d] = idx_q[d];
			end
			at_end[d] = ({1'b0, cur[d]} + (IDX_W+1)'(1)) >= {1'b0, ext_eff[d]};
		end
		for (int k = NDIM - 1; k >= 0; k--) begin
			if (!carry) begin
				nxt[k] = cur[k];
			end else if (at_end[k]) begin
				nxt[k] = '0;
			end else begin
				nxt[k] = cur[k] + IDX_W'(1);
				carry  = 1'b0;
			end
		end
		wrap    = carry;
		lin_cur = item.restart ? '0 : lin_q;
		lin_nxt = wrap ? '0 : lin_cur + CNT_W'(1);
	end

	assign item.ready = !q_full;
	assign q_push     = item.valid && !q_full;

	assign q_entry.idx       = cur;
	assign q_entry.tag.lin   = lin_cur;
	assign q_entry.tag.last  = &at_end;
	assign q_entry.tag.value = item.element_value;

	// Advance the walk on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			lin_q <= '0;
		end else if (q_push) begin
			idx_q <= nxt;
			lin_q <= lin_nxt;
		end
	end

endmodule

// File: hw/rtl/staw_queue.sv
// Short FIFO that decouples the front end from the address pipeline.
module staw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  staw_pkg::walk_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output staw_pkg::walk_t head_data
);
	import staw_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	walk_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full       = count_q == CNT_QW'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem[rd_ptr_q];

	// Store the pushed entry.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Move pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/staw_back.sv
// Back end: three-stage pipeline that turns indices into a strided address.
module staw_back #(
	parameter int ADDR_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  staw_pkg::addr_cfg_t addr_cfg,
	input  logic                q_valid,
	input  staw_pkg::walk_t     q_entry,
	output logic                q_pop,
	staw_result_if.source       result
);
	import staw_pkg::*;

	localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int PW = IDX_W + STRIDE_W;

	logic                  adv;
	logic [NDIM-1:0][PW-1:0] prod;

	logic                  v_s1, v_s2, v_s3;
	tag_t                  tag_s1, tag_s2, tag_s3;
	logic [NDIM-1:0][AW-1:0] prod_s1;
	logic [AW-1:0]         sum_a_s2, sum_b_s2;
	logic [AW-1:0]         addr_s3;

	// Whole pipeline moves when the output register is free or being drained.
	assign adv   = !v_s3 || result.ready;
	assign q_pop = q_valid && adv;

	// Form index-times-stride terms.
	always_comb begin
		for (int d = 0; d < NDIM; d++) begin
			prod[d] = q_entry.idx[d] * addr_cfg.stride[d];
		end
	end

	// Advance valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Register products, then partial sums, then the final address.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < NDIM; d++) begin
				prod_s1[d] <= prod[d][AW-1:0];
			end
			tag_s1   <= q_entry.tag;
			sum_a_s2 <= prod_s1[0] + prod_s1[1];
			sum_b_s2 <= prod_s1[2] + addr_cfg.base[AW-1:0];
			tag_s2   <= tag_s1;
			addr_s3  <= sum_a_s2 + sum_b_s2;
			tag_s3   <= tag_s2;
		end
	end

	assign result.valid           = v_s3;
	assign result.strided_address = ADDR_W'(addr_s3);
	assign result.linear_index    = tag_s3.lin;
	assign result.value_out       = tag_s3.value;
	assign result.last_element    = tag_s3.last;

endmodule

// File: hw/rtl/strided_tensor_address_walker_unit.sv
// Top level of the strided tensor address walker: registers, front, queue, back.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    restart, element_value
//   result   out  valid/ready    strided_address, linear_index, value_out, last_element
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// One item per clock while results are taken; the index walk in the front end closes its
// carry combinationally. An accepted item passes the queue and three address stages.
// Reset clears the counters and loads the register reset values; no clearing pass.
// A stalled result freezes the three-stage address pipeline; the front keeps accepting
// until the four-entry queue is full.
module strided_tensor_address_walker_unit #(
	parameter int DIMS        = 3,
	parameter int EXTENT_BITS = 16,
	parameter int ADDR_BITS   = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [staw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [staw_pkg::CFG_DATA_W-1:0]  cfg_data,
	staw_item_if.sink                        item,
	staw_result_if.source                    result
);
	import staw_pkg::*;

	extent_cfg_t ext_cfg_q;
	addr_cfg_t   addr_cfg_q;

	logic  q_push, q_full, q_pop, q_valid;
	walk_t q_entry, q_head;

	// Hold the configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_cfg_q.extent  <= {NDIM{IDX_W'(1)}};
			addr_cfg_q.stride <= {STRIDE_W'(1), STRIDE_W'(0), STRIDE_W'(0)};
			addr_cfg_q.base   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EXTENT_OUTER:  ext_cfg_q.extent[0]  <= cfg_data[IDX_W-1:0];
				REG_EXTENT_MIDDLE: ext_cfg_q.extent[1]  <= cfg_data[IDX_W-1:0];
				REG_EXTENT_INNER:  ext_cfg_q.extent[2]  <= cfg_data[IDX_W-1:0];
				REG_STRIDE_OUTER:  addr_cfg_q.stride[0] <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_MIDDLE: addr_cfg_q.stride[1] <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_INNER:  addr_cfg_q.stride[2] <= cfg_data[STRIDE_W-1:0];
				REG_BASE_OFFSET:   addr_cfg_q.base      <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	staw_front #(
		.DIMS        (DIMS),
		.EXTENT_BITS (EXTENT_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.ext_cfg (ext_cfg_q),
		.item    (item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	staw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	staw_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr_cfg (addr_cfg_q),
		.q_valid  (q_valid),
		.q_entry  (q_head),
		.q_pop    (q_pop),
		.result   (result)
	);

endmodule

// File: hw/rtl/staw_checker.sv
// Port-level checks of the walker, bound to the top level.
module staw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [staw_pkg::ADDR_W-1:0] strided_address,
	input logic [staw_pkg::CNT_W-1:0]  linear_index,
	input logic [staw_pkg::DATA_W-1:0] value_out,
	input logic                        last_element
);
	import staw_pkg::*;

	logic             item_beat, result_beat;
	logic [3:0]       outstanding_q;
	logic             seen_q;
	logic             prev_last_q;
	logic [CNT_W-1:0] prev_lin_q;

	assign item_beat   = item_valid && item_ready;
	assign result_beat = result_valid && result_ready;

	// Track beats in flight and the previous delivered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			seen_q        <= 1'b0;
			prev_last_q   <= 1'b0;
			prev_lin_q    <= '0;
		end else begin
			if (item_beat && !result_beat) begin
				outstanding_q <= outstanding_q + 4'd1;
			end else if (result_beat && !item_beat) begin
				outstanding_q <= outstanding_q - 4'd1;
			end
			if (result_beat) begin
				seen_q      <= 1'b1;
				prev_last_q <= last_element;
				prev_lin_q  <= linear_index;
			end
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(strided_address)
			&& $stable(linear_index) && $stable(value_out)
			&& $stable(last_element))
		else $error("result payload changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> outstanding_q != 4'd0)
		else $error("result shown with no item in flight");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == 4'd0 |-> item_ready)
		else $error("item not taken while the block is empty");

	a_lin_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_beat && seen_q |-> linear_index == '0
			|| (!prev_last_q && linear_index == prev_lin_q + CNT_W'(1)))
		else $error("linear index neither restarts nor steps by one");

endmodule

bind strided_tensor_address_walker_unit staw_checker u_staw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.strided_address (result.strided_address),
	.linear_index    (result.linear_index),
	.value_out       (result.value_out),
	.last_element    (result.last_element)
);
